// ----- hw/rtl/wsct_pkg.sv -----
`timescale 1ns / 1ps
// Package for the wakeup source counter table.
// Holds the opcode, status and sequencer codes and the default table size.
// No dependencies.
package wsct_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 30;
  localparam int unsigned ID_W              = 16;
  localparam int unsigned CNT_W             = 32;
  localparam int unsigned TIME_W            = 48;
  localparam int unsigned CHAN_W            = 32;
  localparam int unsigned APB_ADDR_W        = 3;
  localparam int unsigned APB_DATA_W        = 32;

  localparam logic [ID_W-1:0] HOLDOFF_RST = 16'd1000;
  localparam logic [ID_W-1:0] RESUME_RST  = 16'd999;

  // register index, taken from paddr[2]
  localparam logic REG_HOLDOFF = 1'b0;
  localparam logic REG_RESUME  = 1'b1;

  typedef enum logic [1:0] {
    OP_CHAN   = 2'd0,
    OP_RESUME = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_RECORDED = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_INVALID  = 3'd3,
    ST_DUMP     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_RESULT,
    S_DUMP
  } state_e;

endpackage

// ----- hw/rtl/wakeup_source_counter_table.sv -----
`timescale 1ns / 1ps
// Wakeup source counter table: top level with the table memory and sequencer.
// Depends on wsct_pkg.
//
// Counts wakeup requests per source id in a table of (id, count) entries held
// in a single-port synchronous memory with a registered read. A channel or
// resume request that is ignored by the holdoff or rejected as invalid goes
// from S_CHECK straight to S_RESULT; one that is recorded or finds the table
// full passes through S_SCAN, which reads one entry per cycle through the
// memory read port. A dump request gives TABLE_ENTRIES results, one per
// cycle while the output is taken, and clears the table at its end through
// per-entry valid bits, so no clearing pass is needed after reset. One
// request is worked on at a time; the next one is taken while the last
// result still waits in the output register.
module wakeup_source_counter_table #(
  parameter int unsigned TABLE_ENTRIES = wsct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request: [31:0] chan_id, [79:32] now_ms
  input  logic [79:0]                          s_axis_tdata,
  // request: [1:0] opcode
  input  logic [1:0]                           s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // result: [15:0] entry_id, [47:16] entry_count
  output logic [47:0]                          m_axis_tdata,
  // result: [2:0] status
  output logic [2:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wsct_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [wsct_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [wsct_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import wsct_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ENT_W = ID_W + CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [1:0]          op_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [TIME_W-1:0]   now_q;
  logic [ID_W-1:0]     key_q, key_d;
  status_e             status_q, status_d;
  logic [TIME_W-1:0]   last_time_q, last_time_d;
  logic [ID_W-1:0]     holdoff_q, resume_q;

  logic [ENT_W-1:0]    mem_q [TABLE_ENTRIES];
  logic [ENT_W-1:0]    rd_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                rd_en, wr_en, clear_all;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENT_W-1:0]    wr_data;

  logic                m_valid_q;
  status_e             m_status_q;
  logic [ID_W-1:0]     m_id_q;
  logic [CNT_W-1:0]    m_cnt_q;
  logic                m_last_q;

  logic                ld;
  status_e             ld_status;
  logic [ID_W-1:0]     ld_id;
  logic [CNT_W-1:0]    ld_cnt;
  logic                ld_last;

  logic                s_acc, slot_free, held, is_last;
  logic [TIME_W-1:0]   diff;
  logic [ID_W-1:0]     ent_id;
  logic [CNT_W-1:0]    ent_cnt;
  logic                cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[2])
      REG_HOLDOFF: prdata = {{(APB_DATA_W-ID_W){1'b0}}, holdoff_q};
      REG_RESUME:  prdata = {{(APB_DATA_W-ID_W){1'b0}}, resume_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q <= HOLDOFF_RST;
      resume_q  <= RESUME_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HOLDOFF: holdoff_q <= pwdata[ID_W-1:0];
        REG_RESUME:  resume_q  <= pwdata[ID_W-1:0];
      endcase
    end
  end

  // handshake helpers
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign slot_free     = ~m_valid_q | m_axis_tready;

  assign diff    = now_q - last_time_q;
  assign held    = diff < {{(TIME_W-ID_W){1'b0}}, holdoff_q};
  assign is_last = (idx_q == LAST_IDX);
  assign ent_id  = valid_q[idx_q] ? rd_q[ID_W-1:0] : '0;
  assign ent_cnt = valid_q[idx_q] ? rd_q[ENT_W-1:ID_W] : '0;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    key_d       = key_q;
    status_d    = status_q;
    last_time_d = last_time_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    wr_data     = rd_q;
    clear_all   = 1'b0;
    ld          = 1'b0;
    ld_status   = status_q;
    ld_id       = '0;
    ld_cnt      = '0;
    ld_last     = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        idx_d   = '0;
        if (op_q == OP_DUMP) begin
          state_d = S_DUMP;
        end else if (op_q == OP_CHAN || op_q == OP_RESUME) begin
          if (held) begin
            status_d = ST_IGNORED;
            state_d  = S_RESULT;
          end else begin
            last_time_d = now_q;
            if (op_q == OP_CHAN && |chan_q[CHAN_W-1:ID_W]) begin
              status_d = ST_INVALID;
              state_d  = S_RESULT;
            end else begin
              key_d   = (op_q == OP_RESUME) ? resume_q : chan_q[ID_W-1:0];
              state_d = S_SCAN;
            end
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ent_id == key_q) begin
          wr_en    = 1'b1;
          wr_data  = {ent_cnt + 1'b1, ent_id};
          status_d = ST_RECORDED;
          state_d  = S_RESULT;
        end else if (ent_id == '0) begin
          wr_en    = 1'b1;
          wr_data  = {CNT_W'(1), key_q};
          status_d = ST_RECORDED;
          state_d  = S_RESULT;
        end else if (is_last) begin
          status_d = ST_FULL;
          state_d  = S_RESULT;
        end else begin
          idx_d   = idx_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          ld      = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          ld        = 1'b1;
          ld_status = ST_DUMP;
          ld_id     = ent_id;
          ld_cnt    = ent_cnt;
          ld_last   = is_last;
          if (is_last) begin
            clear_all = 1'b1;
            state_d   = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_time_q <= '0;
      valid_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_time_q <= last_time_d;
      if (clear_all) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (ld) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    status_q <= status_d;
    if (s_acc) begin
      op_q   <= s_axis_tuser;
      chan_q <= s_axis_tdata[CHAN_W-1:0];
      now_q  <= s_axis_tdata[CHAN_W +: TIME_W];
    end
    if (ld) begin
      m_status_q <= ld_status;
      m_id_q     <= ld_id;
      m_cnt_q    <= ld_cnt;
      m_last_q   <= ld_last;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_cnt_q, m_id_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- hw/rtl/wsct_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the wakeup source counter table, bound to the top.
// Depends on wsct_pkg and wakeup_source_counter_table.
module wsct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);
  import wsct_pkg::*;

  // a result held back keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // wakeup results are single and carry no entry
  a_wake_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_DUMP |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("malformed wakeup result");

  // a dump run is not broken by a new request
  a_dump_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_DUMP && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken during dump");

endmodule

bind wakeup_source_counter_table wsct_checker u_wsct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ----- tb/wsct_table_checker.sv -----
`timescale 1ns / 1ps
// Checker for the wakeup source counter table: watches the request, result and
// register ports, keeps its own copy of the table and compares every result.
// Depends on wsct_pkg.
module wsct_table_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [79:0]                      s_axis_tdata,
  input  logic [1:0]                       s_axis_tuser,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [47:0]                      m_axis_tdata,
  input  logic [2:0]                       m_axis_tuser,
  input  logic                             m_axis_tlast,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsct_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wsct_pkg::APB_DATA_W-1:0]  pwdata,
  input  logic [wsct_pkg::APB_DATA_W-1:0]  prdata,
  input  logic                             pready,
  output int                               mismatches_o,
  output int                               pending_o,
  output int                               requests_o,
  output int                               results_o
);
  import wsct_pkg::*;

  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    logic             last;
  } table_result_t;

  logic [ID_W-1:0]   src_ids    [TABLE_ENTRIES_DEF];
  logic [CNT_W-1:0]  src_counts [TABLE_ENTRIES_DEF];
  logic [TIME_W-1:0] last_stamp;
  logic [ID_W-1:0]   holdoff;
  logic [ID_W-1:0]   resume_id;
  table_result_t     due_records[$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    requests_o   = 0;
    results_o    = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches_o < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  task automatic clear_table();
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      src_ids[i]    = '0;
      src_counts[i] = '0;
    end
  endtask

  // first matching id wins, else the first empty slot is claimed
  function automatic status_e bump_source(input logic [ID_W-1:0] src);
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      if (src_ids[i] == src) begin
        src_counts[i] = src_counts[i] + 1'b1;
        return ST_RECORDED;
      end
      if (src_ids[i] == '0) begin
        src_ids[i]    = src;
        src_counts[i] = 1;
        return ST_RECORDED;
      end
    end
    return ST_FULL;
  endfunction

  task automatic update_wakeup_table(input logic [1:0] op, input logic [CHAN_W-1:0] chan,
                                     input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] since;
    status_e           st;
    since = now - last_stamp;
    if (op == OP_DUMP) begin
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
        due_records.push_back('{ST_DUMP, src_ids[i], src_counts[i],
                                i == TABLE_ENTRIES_DEF - 1});
      clear_table();
    end else if (op == OP_CHAN || op == OP_RESUME) begin
      if (since < TIME_W'(holdoff)) begin
        st = ST_IGNORED;
      end else begin
        last_stamp = now;
        if (op == OP_RESUME) st = bump_source(resume_id);
        else if (chan[CHAN_W-1:ID_W] != '0) st = ST_INVALID;
        else st = bump_source(chan[ID_W-1:0]);
      end
      due_records.push_back('{st, '0, '0, 1'b1});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    table_result_t    want;
    logic [ID_W-1:0]  reg_val;
    if (!rst_ni) begin
      clear_table();
      last_stamp = '0;
      holdoff    = HOLDOFF_RST;
      resume_id  = RESUME_RST;
      due_records.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_HOLDOFF) holdoff = pwdata[ID_W-1:0];
          else resume_id = pwdata[ID_W-1:0];
        end else begin
          reg_val = (paddr[2] == REG_HOLDOFF) ? holdoff : resume_id;
          if (prdata !== APB_DATA_W'(reg_val))
            report_mismatch($sformatf("register read at %0d gave %0h, want %0h",
                                      paddr, prdata, reg_val));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        requests_o++;
        update_wakeup_table(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[79:32]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (due_records.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected, status %0d",
                                    results_o, m_axis_tuser));
        end else begin
          want = due_records.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      results_o, m_axis_tuser, want.status));
          if (m_axis_tdata[15:0] !== want.id)
            report_mismatch($sformatf("result %0d entry_id %0h, want %0h",
                                      results_o, m_axis_tdata[15:0], want.id));
          if (m_axis_tdata[47:16] !== want.count)
            report_mismatch($sformatf("result %0d entry_count %0h, want %0h",
                                      results_o, m_axis_tdata[47:16], want.count));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("result %0d last %0b, want %0b",
                                      results_o, m_axis_tlast, want.last));
        end
      end
      pending_o <= due_records.size();
    end
  end

endmodule

// ----- tb/tb_wakeup_source_counter_table.sv -----
`timescale 1ns / 1ps
// Testbench top for the wakeup source counter table: clock, reset, requests,
// register writes, result back-pressure and the verdict.
// Depends on wsct_pkg, wsct_table_checker and wakeup_source_counter_table.
module tb_wakeup_source_counter_table;
  import wsct_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         PHASES      = 5;
  localparam int         SETTLE      = 40;
  localparam int         LONG_HOLD   = 300;
  localparam int         MIXED_ITEMS = 22;
  localparam int         CYCLE_LIMIT = 300000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [79:0]           s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches, pending, requests, results;
  int stall_pct = 0;
  int idle_pct  = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles    = 0;

  logic [TIME_W-1:0] t_ms;
  logic [ID_W-1:0]   cur_holdoff;

  wakeup_source_counter_table DUT (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  wsct_table_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .requests_o   (requests),
    .results_o    (results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb_wakeup_source_counter_table: errors");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen     <= hold_reqs;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [CHAN_W-1:0] chan,
                              input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {now, chan};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // waits for every outstanding result, then lets the sequencer settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic reg_sel,
                            input logic [ID_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] next_slot();
    return t_ms + TIME_W'(cur_holdoff) + TIME_W'($urandom_range(40));
  endfunction

  // distinct ids past the table size, then a repeat of the first one
  task automatic fill_table();
    logic [ID_W-1:0] base;
    base = ID_W'($urandom_range(16'hFFFF - 40, 1));
    for (int i = 0; i < TABLE_ENTRIES_DEF + 2; i++) begin
      t_ms = next_slot();
      send_request(OP_CHAN, CHAN_W'(base + ID_W'(i)), t_ms);
    end
    t_ms = next_slot();
    send_request(OP_CHAN, CHAN_W'(base), t_ms);
  endtask

  task automatic send_mixed(input int unsigned id_hi);
    int unsigned       pick;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(99);
    chan = $urandom;
    if (pick < 45) begin
      t_ms = next_slot();
      send_request(OP_CHAN, CHAN_W'($urandom_range(id_hi, 1)), t_ms);
    end else if (pick < 52) begin
      t_ms = next_slot();
      send_request(OP_CHAN, '0, t_ms);
    end else if (pick < 59) begin
      t_ms = next_slot();
      send_request(OP_CHAN, {16'($urandom_range(16'hFFFF, 1)), chan[15:0]}, t_ms);
    end else if (pick < 68) begin
      t_ms = next_slot();
      send_request(OP_RESUME, chan, t_ms);
    end else if (pick < 76) begin
      now = t_ms + ((cur_holdoff == 0) ? '0 : TIME_W'($urandom_range(cur_holdoff - 1)));
      send_request(OP_CHAN, CHAN_W'($urandom_range(id_hi, 1)), now);
    end else if (pick < 84) begin
      send_request(OP_DUMP, chan, {16'($urandom), 32'($urandom)});
    end else if (pick < 88) begin
      send_request(OP_UNUSED, chan, {16'($urandom), 32'($urandom)});
    end else begin
      t_ms = {16'($urandom), 32'($urandom)};
      if (pick < 94) chan[31:16] = '0;
      send_request(2'($urandom_range(2)), chan, t_ms);
    end
  endtask

  initial begin
    logic [ID_W-1:0] hold_val, res_val;
    int unsigned     id_hi;
    bit              squeeze;

    cur_holdoff = HOLDOFF_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset register values
    send_request(OP_CHAN,   32'd1,          48'd5);
    send_request(OP_CHAN,   32'd1,          48'd1000);
    send_request(OP_CHAN,   32'd1,          48'd1999);
    send_request(OP_CHAN,   32'hFFFF_0000,  48'd2000);
    send_request(OP_CHAN,   32'd1,          48'd2500);
    send_request(OP_CHAN,   32'd0,          48'd3000);
    send_request(OP_CHAN,   32'd0,          48'd4000);
    send_request(OP_CHAN,   32'h0000_FFFF,  48'd5000);
    send_request(OP_RESUME, 32'hFFFF_FFFF,  48'd6000);
    send_request(OP_RESUME, 32'd0,          48'd7000);
    send_request(OP_UNUSED, $urandom,       48'd8000);
    send_request(OP_CHAN,   32'd1,          48'd8000);
    send_request(OP_CHAN,   32'h0001_0000,  48'd9000);
    send_request(OP_CHAN,   32'h8000_0000,  48'd10000);
    send_request(OP_CHAN,   32'h0000_7FFF,  48'hFFFF_FFFF_FFFF);
    send_request(OP_CHAN,   32'd2,          48'd500);
    send_request(OP_CHAN,   32'd2,          48'd999);
    send_request(OP_DUMP,   $urandom,       48'd0);
    send_request(OP_CHAN,   32'd3,          48'd999);
    send_request(OP_CHAN,   32'd3,          48'd1999);
    send_request(OP_DUMP,   32'd0,          48'hFFFF_FFFF_FFFF);
    send_request(OP_CHAN,   32'hFFFF_FFFF,  48'hFFFF_FFFF_FFFF);
    t_ms = 48'hFFFF_FFFF_FFFF;

    for (int p = 0; p < PHASES; p++) begin
      squeeze = 1'b0;
      unique case (p)
        0: begin
          hold_val = HOLDOFF_RST; res_val = RESUME_RST; id_hi = 12;
          idle_pct = 0;  stall_pct <= 0;  squeeze = 1'b1;
        end
        1: begin
          hold_val = '0; res_val = '0; id_hi = 45;
          idle_pct = 67; stall_pct <= 0;
        end
        2: begin
          hold_val = 16'hFFFF; res_val = 16'hFFFF; id_hi = 20;
          idle_pct = 0;  stall_pct <= 67;
        end
        3: begin
          hold_val = 16'($urandom); res_val = 16'($urandom); id_hi = 60;
          idle_pct = 30; stall_pct <= 30; squeeze = 1'b1;
        end
        default: begin
          hold_val = 16'd1; res_val = 16'($urandom); id_hi = 30;
          idle_pct = 0;  stall_pct <= 0;
        end
      endcase
      drain();
      apb_access(1'b1, REG_HOLDOFF, hold_val);
      apb_access(1'b1, REG_RESUME, res_val);
      apb_access(1'b0, REG_HOLDOFF, '0);
      apb_access(1'b0, REG_RESUME, '0);
      cur_holdoff = hold_val;

      send_request(OP_DUMP, $urandom, t_ms);
      fill_table();
      if (squeeze) begin
        // results held back long enough for the input side to back up
        hold_reqs <= hold_reqs + 1;
        send_request(OP_DUMP, $urandom, t_ms);
        repeat (8) send_mixed(id_hi);
        drain();
      end
      repeat (MIXED_ITEMS) send_mixed(id_hi);
    end
    drain();

    $display("covered %0d requests and %0d results over %0d register settings",
             requests, results, PHASES + 1);
    $display("incl. holdoff rejects, time wrap, invalid and zero ids, full table, dumps");
    if (mismatches == 0 && pending == 0) begin
      $display("tb_wakeup_source_counter_table: clean");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("tb_wakeup_source_counter_table: errors");
    end
    $finish;
  end

endmodule
